/* hdl/dense_graph_shortest_path_core_assert.svh */
// Assertion macros for the shortest path core
`ifndef DENSE_GRAPH_SHORTEST_PATH_CORE_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATH_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DGSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dgsp assertion failed");
`define DGSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dgsp assertion failed");
`else
`define DGSP_ASSERT_IMP(lbl, ante, cons)
`define DGSP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hdl/dgsp_pkg.sv */
// Types and constants shared by the shortest path core
`timescale 1ns / 1ps
`default_nettype none
package dgsp_pkg;
  localparam int NODE_W = 7;
  localparam int IN_WEIGHT_W = 16;
  localparam int OUT_W = 22;
  localparam logic [OUT_W-1:0] PATH_MAX = {OUT_W{1'b1}};
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2
  } act_e;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_EDGE_RD  = 11'b00000000100,
    S_EDGE_CMP = 11'b00000001000,
    S_EDGE_WR2 = 11'b00000010000,
    S_INIT     = 11'b00000100000,
    S_SCAN     = 11'b00001000000,
    S_RELAX    = 11'b00010000000,
    S_FETCH    = 11'b00100000000,
    S_FETCH2   = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_e;
endpackage
`default_nettype wire

/* hdl/dense_graph_shortest_path_core.sv */
// Dense graph shortest path core: adjacency matrix memory and Dijkstra sequencer
// Clear: steps through every matrix entry, one matrix entry per cycle.
// Add edge: read, compare; if new or lighter, two writes through the single write port.
// Query: for N live nodes, one compare/add unit visits one node per cycle in each
// selection and relaxation pass.
// Reset: runs the matrix clearing pass; no item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "dense_graph_shortest_path_core_assert.svh"
module dense_graph_shortest_path_core
  import dgsp_pkg::*;
#(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [NODE_W-1:0] cfg_data_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // edge_from, edge_to, edge_weight, source_node, target_node, zero fill
  input  wire logic [47:0]       s_axis_tdata,
  // action
  input  wire logic [1:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // path_length, zero fill
  output logic [23:0]            m_axis_tdata,
  // reachable
  output logic                   m_axis_tuser
);
  localparam int IDX_W  = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int CMP_W  = (CNT_W > NODE_W) ? CNT_W : NODE_W;
  localparam int AW     = 2 * IDX_W;
  localparam int DIST_W = WEIGHT_BITS + IDX_W;
  localparam int ENT_W  = WEIGHT_BITS + 1;

  state_e state_q, state_d;
  logic [NODE_W-1:0] node_count_q;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] j_q;
  logic [IDX_W-1:0] j_idx, jq_q;
  logic pv_q;
  logic [AW-1:0] clr_q;
  logic [IDX_W-1:0] a_q, b_q, s_q, t_q, pick_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic found_q;
  logic [DIST_W-1:0] best_q;
  logic res_reach_q;
  logic [OUT_W-1:0] res_len_q;
  logic [OUT_W-1:0] m_len_q;
  logic m_reach_q, m_valid_q;
  logic [2**IDX_W-1:0] settled_q, known_q;

  logic [ENT_W-1:0] mat_mem [2**AW];
  logic [ENT_W-1:0] mat_rdata_q, mat_wdata;
  logic [AW-1:0] mat_waddr, mat_raddr;
  logic mat_we;
  logic [DIST_W-1:0] dist_mem [2**IDX_W];
  logic [DIST_W-1:0] dist_rdata_q, dist_wdata;
  logic [IDX_W-1:0] dist_waddr, dist_raddr;
  logic dist_we;

  logic accept, issue, loop_done, cand, edge_upd;
  logic [DIST_W-1:0] relax_sum;
  logic [NODE_W-1:0] in_from, in_to, in_src, in_tgt;
  logic [IN_WEIGHT_W-1:0] in_w;
  logic ab_ok, st_ok;
  logic [CMP_W-1:0] lim_cmp, nc_cmp;

  assign in_from = s_axis_tdata[6:0];
  assign in_to   = s_axis_tdata[13:7];
  assign in_w    = s_axis_tdata[29:14];
  assign in_src  = s_axis_tdata[36:30];
  assign in_tgt  = s_axis_tdata[43:37];

  assign nc_cmp  = CMP_W'(node_count_q);
  assign lim_cmp = (nc_cmp > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : nc_cmp;
  assign lim     = lim_cmp[CNT_W-1:0];
  assign ab_ok   = (in_from != '0) && (in_to != '0) &&
                   (CMP_W'(in_from) <= lim_cmp) && (CMP_W'(in_to) <= lim_cmp);
  assign st_ok   = (in_src != '0) && (in_tgt != '0) &&
                   (CMP_W'(in_src) <= lim_cmp) && (CMP_W'(in_tgt) <= lim_cmp);

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(24 - OUT_W){1'b0}}, m_len_q};
  assign m_axis_tuser  = m_reach_q;

  assign j_idx = j_q[IDX_W-1:0];
  assign issue = ((state_q == S_INIT) || (state_q == S_SCAN) || (state_q == S_RELAX)) &&
                 (j_q < lim);
  assign loop_done = !issue && !pv_q;
  assign relax_sum = best_q + DIST_W'(mat_rdata_q[WEIGHT_BITS-1:0]);
  assign cand = pv_q && !settled_q[jq_q] && known_q[jq_q] &&
                (!found_q || (dist_rdata_q < best_q));
  assign edge_upd = !mat_rdata_q[WEIGHT_BITS] || (w_q < mat_rdata_q[WEIGHT_BITS-1:0]);

  always_comb begin
    mat_we     = 1'b0;
    mat_waddr  = '0;
    mat_wdata  = '0;
    mat_raddr  = '0;
    dist_we    = 1'b0;
    dist_waddr = jq_q;
    dist_wdata = '0;
    dist_raddr = j_idx;
    case (state_q)
      S_CLEAR: begin
        mat_we    = 1'b1;
        mat_waddr = clr_q;
        mat_wdata = {clr_q[AW-1:IDX_W] == clr_q[IDX_W-1:0], {WEIGHT_BITS{1'b0}}};
      end
      S_EDGE_RD: mat_raddr = {a_q, b_q};
      S_EDGE_CMP: begin
        mat_we    = edge_upd;
        mat_waddr = {a_q, b_q};
        mat_wdata = {1'b1, w_q};
      end
      S_EDGE_WR2: begin
        mat_we    = 1'b1;
        mat_waddr = {b_q, a_q};
        mat_wdata = {1'b1, w_q};
      end
      S_INIT: begin
        mat_raddr  = {s_q, j_idx};
        dist_we    = pv_q;
        dist_wdata = ((jq_q == s_q) || !mat_rdata_q[WEIGHT_BITS]) ? '0 :
                     DIST_W'(mat_rdata_q[WEIGHT_BITS-1:0]);
      end
      S_RELAX: begin
        mat_raddr  = {pick_q, j_idx};
        dist_we    = pv_q && !settled_q[jq_q] && mat_rdata_q[WEIGHT_BITS] &&
                     (!known_q[jq_q] || (relax_sum < dist_rdata_q));
        dist_wdata = relax_sum;
      end
      S_FETCH: dist_raddr = t_q;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:    if (clr_q == {AW{1'b1}}) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            ACT_CLEAR: state_d = S_CLEAR;
            ACT_ADD:   state_d = ab_ok ? S_EDGE_RD : S_IDLE;
            ACT_QUERY: state_d = st_ok ? S_INIT : S_DONE;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_EDGE_RD:  state_d = S_EDGE_CMP;
      S_EDGE_CMP: state_d = edge_upd ? S_EDGE_WR2 : S_IDLE;
      S_EDGE_WR2: state_d = S_IDLE;
      S_INIT:     if (loop_done) state_d = S_SCAN;
      S_SCAN:     if (loop_done) state_d = found_q ? S_RELAX : S_FETCH;
      S_RELAX:    if (loop_done) state_d = S_SCAN;
      S_FETCH:    state_d = S_FETCH2;
      S_FETCH2:   state_d = S_DONE;
      S_DONE:     if (!m_valid_q || m_axis_tready) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    mat_rdata_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rdata_q <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= IDX_W'(in_from - 7'd1);
      b_q <= IDX_W'(in_to - 7'd1);
      s_q <= IDX_W'(in_src - 7'd1);
      t_q <= IDX_W'(in_tgt - 7'd1);
      w_q <= WEIGHT_BITS'(in_w);
    end
    if (cand) begin
      best_q <= dist_rdata_q;
      pick_q <= jq_q;
    end
    jq_q <= j_idx;
    if (state_q == S_FETCH2) begin
      res_reach_q <= known_q[t_q];
      res_len_q   <= !known_q[t_q] ? '0 :
                     (dist_rdata_q > DIST_W'(PATH_MAX)) ? PATH_MAX : OUT_W'(dist_rdata_q);
    end else if (accept) begin
      res_reach_q <= 1'b0;
      res_len_q   <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      node_count_q <= NODE_COUNT_RST;
      clr_q        <= '0;
      j_q          <= '0;
      pv_q         <= 1'b0;
      found_q      <= 1'b0;
      m_valid_q    <= 1'b0;
      m_reach_q    <= 1'b0;
      m_len_q      <= '0;
      settled_q    <= '0;
      known_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        node_count_q <= cfg_data_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end else begin
        clr_q <= '0;
      end
      pv_q <= issue;
      if (issue) begin
        j_q <= j_q + 1'b1;
      end else if (loop_done || (state_q == S_IDLE)) begin
        j_q <= '0;
      end
      if ((state_q == S_SCAN) && cand) begin
        found_q <= 1'b1;
      end else if ((state_q != S_SCAN) && (state_d == S_SCAN)) begin
        found_q <= 1'b0;
      end
      if ((state_q == S_INIT) && pv_q) begin
        settled_q[jq_q] <= (jq_q == s_q);
        known_q[jq_q]   <= (jq_q == s_q) || mat_rdata_q[WEIGHT_BITS];
      end
      if ((state_q == S_SCAN) && (state_d == S_RELAX)) begin
        settled_q[pick_q] <= 1'b1;
      end
      if (dist_we && (state_q == S_RELAX)) begin
        known_q[jq_q] <= 1'b1;
      end
      if ((state_q == S_DONE) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
        m_reach_q <= res_reach_q;
        m_len_q   <= res_len_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  `DGSP_ASSERT_IMP(a_relax_has_pick, (state_q == S_SCAN) && (state_d == S_RELAX), found_q)
  `DGSP_ASSERT_IMP(a_idle_pipe_empty, state_q == S_IDLE, !pv_q)
  `DGSP_ASSERT_NXT(a_out_from_done, !m_valid_q && (state_q != S_DONE), !m_valid_q)
  `DGSP_ASSERT_NXT(a_clear_ends, (state_q == S_CLEAR) && (clr_q == {AW{1'b1}}), state_q == S_IDLE)
endmodule
`default_nettype wire
